// ===== sv/lmfb_pkg.sv =====
// lmfb_pkg: shared types, codes and the fade function for the led matrix frame buffer
// no dependencies; imported by lmfb_map, lmfb_store, lmfb_seq and the top level
package lmfb_pkg;

  localparam int DEF_MATRIX_WIDTH  = 16;
  localparam int DEF_MATRIX_HEIGHT = 16;

  localparam int CFG_DATA_W  = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_CORNER  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_HEADING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PLAIN_ROWS    = 2'd2;

  // corner and heading packed as {corner, heading}
  localparam logic [3:0] PAIR_BL_UP    = 4'h1;
  localparam logic [3:0] PAIR_TL_RIGHT = 4'h4;
  localparam logic [3:0] PAIR_TL_DOWN  = 4'h7;
  localparam logic [3:0] PAIR_TR_LEFT  = 4'hA;
  localparam logic [3:0] PAIR_TR_DOWN  = 4'hB;
  localparam logic [3:0] PAIR_BR_UP    = 4'hD;
  localparam logic [3:0] PAIR_BR_LEFT  = 4'hE;

  localparam logic [7:0] DIM_FLOOR = 8'd30;

  typedef enum logic [1:0] {
    REQ_DRAW = 2'd0,
    REQ_READ = 2'd1,
    REQ_FADE = 2'd2,
    REQ_FILL = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_ACCESS,
    ST_READ_WAIT,
    ST_FILL,
    ST_FADE,
    ST_FADE_END
  } st_t;

  typedef struct packed {
    logic [1:0] corner;
    logic [1:0] heading;
    logic       plain;
  } cfg_t;

  function automatic logic [23:0] fade_color(input logic [23:0] c, input logic [7:0] step);
    logic [8:0]  k;
    logic [16:0] pr;
    logic [16:0] pg;
    logic [16:0] pb;
    logic        keep;
    k  = 9'd256 - {1'b0, step};
    pr = 17'(c[23:16]) * 17'(k);
    pg = 17'(c[15:8]) * 17'(k);
    pb = 17'(c[7:0]) * 17'(k);
    // a black pixel fails this test too and stays black
    keep = (c[23:16] >= DIM_FLOOR) || (c[15:8] >= DIM_FLOOR) || (c[7:0] >= DIM_FLOOR);
    return keep ? {pr[15:8], pg[15:8], pb[15:8]} : 24'd0;
  endfunction

endpackage

// ===== sv/lmfb_map.sv =====
// lmfb_map: registered x,y to strip index mapping (serpentine or plain)
// depends on lmfb_pkg for cfg_t and the corner/heading pair codes
module lmfb_map import lmfb_pkg::*; #(
  parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT,
  localparam int DIM   = (MATRIX_WIDTH > MATRIX_HEIGHT) ? MATRIX_WIDTH : MATRIX_HEIGHT,
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1,
  localparam int DEPTH = MATRIX_WIDTH * MATRIX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  cfg_t          cfg,
  input  logic [CW-1:0] xs,
  input  logic [CW-1:0] ys,
  output logic [AW-1:0] idx
);

  localparam int RW = CW + 1;
  localparam int PW = CW + RW;

  logic [CW-1:0] xr;
  logic [CW-1:0] yr;
  logic [RW-1:0] run;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [CW-1:0] col_eff;
  logic [AW-1:0] idx_next;

  assign xr = CW'(MATRIX_WIDTH - 1) - xs;
  assign yr = CW'(MATRIX_HEIGHT - 1) - ys;

  always_comb begin
    run = RW'(MATRIX_WIDTH);
    col = xs;
    row = ys;
    case ({cfg.corner, cfg.heading})
      PAIR_BL_UP:    begin run = RW'(MATRIX_HEIGHT); col = ys; row = xs; end
      PAIR_TL_RIGHT: begin run = RW'(MATRIX_WIDTH);  col = xs; row = yr; end
      PAIR_TL_DOWN:  begin run = RW'(MATRIX_HEIGHT); col = yr; row = xs; end
      PAIR_TR_LEFT:  begin run = RW'(MATRIX_WIDTH);  col = xr; row = yr; end
      PAIR_TR_DOWN:  begin run = RW'(MATRIX_HEIGHT); col = yr; row = xr; end
      PAIR_BR_LEFT:  begin run = RW'(MATRIX_WIDTH);  col = xr; row = ys; end
      PAIR_BR_UP:    begin run = RW'(MATRIX_HEIGHT); col = ys; row = xr; end
      default: begin end
    endcase
  end

  // odd rows run backwards unless zigzag is off
  assign col_eff  = (row[0] && !cfg.plain) ? CW'(run - RW'(col) - RW'(1)) : col;
  assign idx_next = AW'(PW'(row) * PW'(run) + PW'(col_eff));

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

endmodule

// ===== sv/lmfb_store.sv =====
// lmfb_store: pixel memory, one write port and one registered read port
// depends on lmfb_pkg only for the default sizes
module lmfb_store import lmfb_pkg::*; #(
  parameter int DEPTH = DEF_MATRIX_WIDTH * DEF_MATRIX_HEIGHT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lmfb_seq.sv =====
// lmfb_seq: request sequencer, pixel sweeps for clear/fill/fade and the result register
// depends on lmfb_pkg; drives lmfb_store and reads the index from lmfb_map
module lmfb_seq import lmfb_pkg::*; #(
  parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT,
  localparam int DIM   = (MATRIX_WIDTH > MATRIX_HEIGHT) ? MATRIX_WIDTH : MATRIX_HEIGHT,
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1,
  localparam int DEPTH = MATRIX_WIDTH * MATRIX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    req_type,
  input  logic [7:0]    x_coord,
  input  logic [7:0]    y_coord,
  input  logic [23:0]   pixel_color,
  input  logic [7:0]    fade_amount,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [23:0]   read_color,
  output logic          outside_matrix,
  output logic [CW-1:0] map_x,
  output logic [CW-1:0] map_y,
  input  logic [AW-1:0] map_idx,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [23:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [23:0]   mem_rdata
);

  localparam logic [7:0]    W8       = 8'(MATRIX_WIDTH);
  localparam logic [7:0]    H8       = 8'(MATRIX_HEIGHT);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  st_t         state;
  st_t         state_next;
  logic [AW-1:0] cnt;
  req_t        req;
  logic [23:0] color;
  logic [7:0]  step;
  logic        on_matrix;
  logic [23:0] res_color;
  logic        pipe_vld;
  logic [AW-1:0] pipe_addr;
  logic        last;
  logic        in_fire;
  logic        in_inside;
  logic        out_free;
  logic        sweeping;
  logic [CW-1:0] x_lat_cw;
  logic [CW-1:0] y_lat_cw;
  logic        res_pending;
  logic        res_load;

  assign last      = (cnt == LAST_IDX);
  assign in_fire   = in_valid && !in_stall;
  assign in_inside = (x_coord < W8) && (y_coord < H8);
  assign out_free  = !out_valid || !out_stall;
  assign sweeping  = (state == ST_CLEAR) || (state == ST_FILL) || (state == ST_FADE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (req_t'(req_type))
            REQ_DRAW, REQ_READ: state_next = in_inside ? ST_MAP : ST_IDLE;
            REQ_FADE:           state_next = ST_FADE;
            default:            state_next = ST_FILL;
          endcase
        end
      end
      ST_MAP:       state_next = ST_ACCESS;
      ST_ACCESS:    state_next = (req == REQ_READ) ? ST_READ_WAIT : ST_IDLE;
      ST_READ_WAIT: state_next = ST_IDLE;
      ST_FILL:      if (last) state_next = ST_IDLE;
      ST_FADE:      if (last) state_next = ST_FADE_END;
      ST_FADE_END:  state_next = ST_IDLE;
      default:      state_next = state;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = color;
    mem_raddr = map_idx;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 24'd0;
      end
      // hold input while a finished result waits for the output register
      ST_IDLE: in_stall = res_pending;
      ST_ACCESS: begin
        mem_we    = (req == REQ_DRAW);
        mem_waddr = map_idx;
      end
      ST_FILL: mem_we = 1'b1;
      ST_FADE, ST_FADE_END: begin
        // read one pixel ahead while the previous one is written back
        mem_raddr = cnt;
        mem_we    = pipe_vld;
        mem_waddr = pipe_addr;
        mem_wdata = fade_color(mem_rdata, step);
      end
      default: begin end
    endcase
  end

  assign map_x = x_lat_cw;
  assign map_y = y_lat_cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt      <= '0;
      pipe_vld <= 1'b0;
    end else begin
      state    <= state_next;
      pipe_vld <= (state == ST_FADE);
      if (sweeping) begin
        cnt <= last ? '0 : cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr <= cnt;
    if (in_fire) begin
      req       <= req_t'(req_type);
      x_lat_cw  <= x_coord[CW-1:0];
      y_lat_cw  <= y_coord[CW-1:0];
      color     <= pixel_color;
      step      <= fade_amount;
      on_matrix <= in_inside || (req_type == REQ_FADE) || (req_type == REQ_FILL);
      res_color <= 24'd0;
    end else if (state == ST_READ_WAIT) begin
      res_color <= mem_rdata;
    end
  end

  // result register: one beat per request, held while stalled
  // an off-matrix draw or read finishes in the cycle it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pending <= 1'b0;
    end else if (res_load) begin
      res_pending <= 1'b0;
    end else if ((state != ST_CLEAR) && (state_next == ST_IDLE) &&
                 ((state != ST_IDLE) || in_fire)) begin
      res_pending <= 1'b1;
    end
  end

  assign res_load = res_pending && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      read_color     <= res_color;
      outside_matrix <= !on_matrix;
    end
  end

endmodule

// ===== sv/led_matrix_frame_buffer.sv =====
// Frame buffer for a serpentine or plain wired LED matrix: one 24-bit RGB word per pixel,
// held in strip order in a single-port-write, registered-read memory. A draw passes the
// index mapping register and the memory access, a read also the read data register; an
// off-matrix draw or read skips them. Fill-all and fade-all sweep every pixel, one memory
// write per cycle, fade reading one pixel ahead of its write-back. After reset a clearing
// pass blacks out the store; input stays stalled until it ends, configuration writes are
// taken throughout. One request is worked on at a time, and the next one may be taken
// while the previous result beat is still waiting on the output; input stalls while a
// finished result waits behind that beat.
module led_matrix_frame_buffer import lmfb_pkg::*; #(
  parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
  parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             req_type,
  input  logic [7:0]             x_coord,
  input  logic [7:0]             y_coord,
  input  logic [23:0]            pixel_color,
  input  logic [7:0]             fade_amount,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [23:0]            read_color,
  output logic                   outside_matrix
);

  localparam int DIM   = (MATRIX_WIDTH > MATRIX_HEIGHT) ? MATRIX_WIDTH : MATRIX_HEIGHT;
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int DEPTH = MATRIX_WIDTH * MATRIX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg;
  logic [CW-1:0] map_x;
  logic [CW-1:0] map_y;
  logic [AW-1:0] map_idx;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [23:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_CORNER:  cfg.corner  <= cfg_data[1:0];
        CFG_STRIP_HEADING: cfg.heading <= cfg_data[1:0];
        CFG_PLAIN_ROWS:    cfg.plain   <= cfg_data[0];
        default: begin end
      endcase
    end
  end

  lmfb_map #(
    .MATRIX_WIDTH (MATRIX_WIDTH),
    .MATRIX_HEIGHT(MATRIX_HEIGHT)
  ) u_map (
    .clk(clk),
    .cfg(cfg),
    .xs (map_x),
    .ys (map_y),
    .idx(map_idx)
  );

  lmfb_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  lmfb_seq #(
    .MATRIX_WIDTH (MATRIX_WIDTH),
    .MATRIX_HEIGHT(MATRIX_HEIGHT)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .pixel_color   (pixel_color),
    .fade_amount   (fade_amount),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_color    (read_color),
    .outside_matrix(outside_matrix),
    .map_x         (map_x),
    .map_y         (map_y),
    .map_idx       (map_idx),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule

// ===== sv/lmfb_checker.sv =====
// lmfb_checker: port-level checks for led_matrix_frame_buffer, bound to the top level
// self-contained; ports match the top level names for the wildcard bind
module lmfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  req_type,
  input logic [7:0]  x_coord,
  input logic [7:0]  y_coord,
  input logic [23:0] pixel_color,
  input logic [7:0]  fade_amount,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] read_color,
  input logic        outside_matrix
);

  // a stalled request beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(req_type) && $stable(x_coord) &&
      $stable(y_coord) && $stable(pixel_color) && $stable(fade_amount))
    else $error("request beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_color) && $stable(outside_matrix))
    else $error("result beat changed while stalled");

  // reset leaves no result and the clearing pass blocks input
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("result or input ready right after reset");

  // an off-matrix request never carries a colour
  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside_matrix |-> read_color == 24'd0)
    else $error("off-matrix result with nonzero colour");

  // one request at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before the first finished");

endmodule

bind led_matrix_frame_buffer lmfb_checker u_lmfb_checker (.*);
